@@ hw/rtl/fxalu_pkg.sv @@
// Shared types, opcodes and saturation helper for the fixed-point ALU.
package fxalu_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic        valid;
        t_op         op;
        logic [31:0] res;
        logic        cond;
        logic [1:0]  status;
        logic        neg;
        logic        bz;
        logic        ovf;
    } t_side;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat;

    function automatic t_sat signed_sat(input logic [63:0] mag, input logic neg);
        t_sat r;
        if (!neg) begin
            r.sat = (mag > {32'd0, POS_MAX});
            r.val = r.sat ? POS_MAX : mag[31:0];
        end else begin
            r.sat = (mag > {32'd0, NEG_MAX});
            r.val = r.sat ? NEG_MAX : (32'd0 - mag[31:0]);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fixed_point_q24_8_alu.sv @@
// Top level: pipelined signed fixed-point ALU with restoring divider lanes.
// One operation is taken every cycle (busy stays low) and every result leaves
// via input, setup, divider and output registers, marked by o_valid for one
// cycle; the latency is set by the 32-stage restoring divider, one quotient
// bit per stage, that every opcode travels alongside. The receiver cannot stall.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    output logic signed [31:0] o_result,
    output logic        o_cond_true,
    output logic [1:0]  o_status
);
    import fxalu_pkg::*;

    localparam int DW  = 32 + FRAC_BITS;
    localparam int CW  = DW + 32;
    localparam int LAT = 35;

    // input stage
    logic        r_v0;
    t_op         r_op0;
    logic [31:0] r_a0, r_b0, r_ma0, r_mb0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start;
        end
        r_op0 <= t_op'(i_opcode);
        r_a0  <= i_operand_a;
        r_b0  <= i_operand_b;
        r_ma0 <= i_operand_a[31] ? (32'd0 - i_operand_a) : i_operand_a;
        r_mb0 <= i_operand_b[31] ? (32'd0 - i_operand_b) : i_operand_b;
    end

    // simple ops, multiply, divider setup
    t_side n_pre;
    logic [DW-1:0] w_dvd;
    logic [DW-1:0] w_dhi;

    always_comb begin
        n_pre        = '0;
        n_pre.valid  = r_v0;
        n_pre.op     = r_op0;
        n_pre.neg    = r_a0[31] ^ r_b0[31];
        n_pre.bz     = (r_b0 == 32'd0);
        n_pre.status = ST_OK;
        case (r_op0)
            OP_ADD:      n_pre.res = r_a0 + r_b0;
            OP_SUB:      n_pre.res = r_a0 - r_b0;
            OP_GT:       n_pre.cond = $signed(r_a0) >  $signed(r_b0);
            OP_LT:       n_pre.cond = $signed(r_a0) <  $signed(r_b0);
            OP_GE:       n_pre.cond = $signed(r_a0) >= $signed(r_b0);
            OP_LE:       n_pre.cond = $signed(r_a0) <= $signed(r_b0);
            OP_EQ:       n_pre.cond = (r_a0 == r_b0);
            OP_NE:       n_pre.cond = (r_a0 != r_b0);
            OP_MIN:      n_pre.res = ($signed(r_a0) > $signed(r_b0)) ? r_b0 : r_a0;
            OP_MAX:      n_pre.res = ($signed(r_a0) < $signed(r_b0)) ? r_b0 : r_a0;
            OP_INC:      n_pre.res = r_a0 + 32'd1;
            OP_DEC:      n_pre.res = r_a0 - 32'd1;
            OP_FROM_INT: n_pre.res = r_a0 << FRAC_BITS;
            OP_TO_INT:   n_pre.res = $unsigned($signed(r_a0) >>> FRAC_BITS);
            default:     n_pre.res = 32'd0;
        endcase
        w_dvd     = {r_ma0, {FRAC_BITS{1'b0}}};
        w_dhi     = w_dvd >> 32;
        n_pre.ovf = (w_dhi >= DW'(r_mb0));
    end

    t_side         r_pre;
    logic [63:0]   r_prod;
    logic [DW-1:0] r_rem [0:32];
    logic [31:0]   r_mb  [0:32];
    logic [31:0]   r_q   [1:32];
    t_side         r_sd  [1:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.valid <= 1'b0;
        end else begin
            r_pre <= n_pre;
        end
        r_prod   <= {32'd0, r_ma0} * {32'd0, r_mb0};
        r_rem[0] <= w_dvd;
        r_mb[0]  <= r_mb0;
    end

    // finish multiply on lane 0
    t_side w_sd0;
    t_sat  w_msat;
    logic [63:0] w_mq;

    always_comb begin
        w_sd0  = r_pre;
        w_mq   = r_prod >> FRAC_BITS;
        w_msat = signed_sat(w_mq, r_pre.neg && (w_mq != 64'd0));
        if (r_pre.op == OP_MUL) begin
            w_sd0.res    = w_msat.val;
            w_sd0.status = w_msat.sat ? ST_OVF : ST_OK;
        end
    end

    // one quotient bit per stage
    genvar k;
    generate
        for (k = 0; k < 32; k++) begin : g_div
            logic [CW-1:0] w_ds;
            logic [CW-1:0] w_rx;
            logic          w_ge;
            logic [31:0]   w_qin;
            t_side         w_sin;

            always_comb begin
                w_ds = {{DW{1'b0}}, r_mb[k]} << (31 - k);
                w_rx = {32'd0, r_rem[k]};
                w_ge = (w_rx >= w_ds);
            end

            if (k == 0) begin : g_first
                assign w_qin = 32'd0;
                assign w_sin = w_sd0;
            end else begin : g_rest
                assign w_qin = r_q[k];
                assign w_sin = r_sd[k];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sd[k+1].valid <= 1'b0;
                end else begin
                    r_sd[k+1] <= w_sin;
                end
                r_rem[k+1] <= w_ge ? DW'(w_rx - w_ds) : r_rem[k];
                r_mb[k+1]  <= r_mb[k];
                r_q[k+1]   <= w_qin | (w_ge ? (32'd1 << (31 - k)) : 32'd0);
            end
        end
    endgenerate

    // output stage
    t_side w_fin;
    t_sat  w_dsat;

    always_comb begin
        w_fin  = r_sd[32];
        w_dsat = signed_sat({32'd0, r_q[32]}, w_fin.neg && (r_q[32] != 32'd0));
        if (w_fin.op == OP_DIV) begin
            if (w_fin.bz) begin
                w_fin.res    = 32'd0;
                w_fin.status = ST_DIVZ;
            end else if (w_fin.ovf) begin
                w_fin.res    = w_fin.neg ? NEG_MAX : POS_MAX;
                w_fin.status = ST_OVF;
            end else begin
                w_fin.res    = w_dsat.val;
                w_fin.status = w_dsat.sat ? ST_OVF : ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_fin.valid;
        end
        o_result    <= w_fin.res;
        o_cond_true <= w_fin.cond;
        o_status    <= w_fin.status;
    end

    assign busy = 1'b0;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without matching start");

    a_divz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZ) |-> (o_result == 32'd0 && !o_cond_true))
        else $error("divide by zero result not cleared");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cond_true) |-> (o_result == 32'd0 && o_status == ST_OK))
        else $error("comparison beat carries result or status");

endmodule
